[hdl/lzo_pkg.sv]
// Shared constants, codes and types of the layer z-order manager.
package lzo_pkg;

  localparam int LAYER_COUNT = 32;
  localparam int ID_W        = 5;
  localparam int REQ_W       = 8;
  localparam int SLOT_W      = 6;
  localparam int CNT_W       = 6;
  localparam int POS_W       = 7;

  typedef enum logic [2:0] {
    ST_SAME  = 3'd0,
    ST_LOWER = 3'd1,
    ST_RAISE = 3'd2,
    ST_SHOW  = 3'd3,
    ST_HIDE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PLAN,
    S_APPLY
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic plan;
    logic apply;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ctl_sts_t;

endpackage

[hdl/lzo_if.sv]
// Valid/ready channel interfaces for requests and results.
interface lzo_req_if;
  logic                               valid;
  logic                               ready;
  logic [lzo_pkg::ID_W-1:0]           layer_sel;
  logic signed [lzo_pkg::REQ_W-1:0]   requested_height;

  modport source (output valid, output layer_sel, output requested_height, input ready);
  modport sink   (input valid, input layer_sel, input requested_height, output ready);
endinterface

interface lzo_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [lzo_pkg::SLOT_W-1:0]  new_slot;
  logic [2:0]                         status;
  logic [lzo_pkg::ID_W-1:0]           map_from;
  logic [lzo_pkg::ID_W-1:0]           draw_from;
  logic signed [lzo_pkg::SLOT_W-1:0]  draw_to;
  logic [lzo_pkg::CNT_W-1:0]          visible_count;

  modport source (output valid, output new_slot, output status, output map_from,
                  output draw_from, output draw_to, output visible_count, input ready);
  modport sink   (input valid, input new_slot, input status, input map_from,
                  input draw_from, input draw_to, input visible_count, output ready);
endinterface

[hdl/lzo_ctl.sv]
// Sequencer: accept, plan, apply one request at a time.
module lzo_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lzo_pkg::ctl_sts_t sts,
  output lzo_pkg::ctl_cmd_t cmd
);

  lzo_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzo_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      lzo_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lzo_pkg::S_PLAN;
        end
      end
      lzo_pkg::S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = lzo_pkg::S_APPLY;
      end
      lzo_pkg::S_APPLY: begin
        if (!sts.out_busy) begin
          cmd.apply = 1'b1;
          state_nxt = lzo_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lzo_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[hdl/lzo_dp.sv]
// Datapath: slot cells, layer slot map, visible count, move planning, result register.
module lzo_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lzo_pkg::ctl_cmd_t                  cmd,
  output lzo_pkg::ctl_sts_t                  sts,
  input  logic [lzo_pkg::ID_W-1:0]           in_layer_sel,
  input  logic signed [lzo_pkg::REQ_W-1:0]   in_requested_height,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [lzo_pkg::SLOT_W-1:0]  out_new_slot,
  output logic [2:0]                         out_status,
  output logic [lzo_pkg::ID_W-1:0]           out_map_from,
  output logic [lzo_pkg::ID_W-1:0]           out_draw_from,
  output logic signed [lzo_pkg::SLOT_W-1:0]  out_draw_to,
  output logic [lzo_pkg::CNT_W-1:0]          out_visible_count
);

  localparam int LC = lzo_pkg::LAYER_COUNT;

  // stack state
  logic [lzo_pkg::ID_W-1:0]          owner_r [LC];
  logic [lzo_pkg::ID_W-1:0]          owner_nxt [LC];
  logic signed [lzo_pkg::SLOT_W-1:0] lslot_r [LC];
  logic signed [lzo_pkg::SLOT_W-1:0] lslot_nxt [LC];
  logic [lzo_pkg::CNT_W-1:0]         vis_r;

  // request hold
  logic [lzo_pkg::ID_W-1:0]          id_r;
  logic signed [lzo_pkg::REQ_W-1:0]  req_r;

  // plan registers
  logic signed [lzo_pkg::SLOT_W-1:0] pl_hc_r;
  lzo_pkg::status_t                  pl_st_r;
  logic signed [lzo_pkg::POS_W-1:0]  pl_rlo_r, pl_rhi_r;
  logic                              pl_up_r;
  logic [lzo_pkg::ID_W-1:0]          pl_map_r, pl_df_r;
  logic signed [lzo_pkg::SLOT_W-1:0] pl_dt_r;
  logic [lzo_pkg::CNT_W-1:0]         pl_vis_r;

  // plan logic
  logic signed [lzo_pkg::SLOT_W-1:0] old;
  logic signed [lzo_pkg::POS_W-1:0]  old7, top7, hc7;
  logic signed [8:0]                 lim9, h9;
  lzo_pkg::status_t                  st_c;
  logic signed [lzo_pkg::POS_W-1:0]  rlo_c, rhi_c;
  logic                              up_c;
  logic [lzo_pkg::ID_W-1:0]          map_c, df_c;
  logic signed [lzo_pkg::SLOT_W-1:0] dt_c;
  logic [lzo_pkg::CNT_W-1:0]         vis_c;
  logic                              place;

  // result register
  logic                              out_valid_r;
  logic signed [lzo_pkg::SLOT_W-1:0] res_slot_r;
  logic [2:0]                        res_st_r;
  logic [lzo_pkg::ID_W-1:0]          res_map_r, res_df_r;
  logic signed [lzo_pkg::SLOT_W-1:0] res_dt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r  <= in_layer_sel;
      req_r <= in_requested_height;
    end
  end

  always_comb begin
    old  = lslot_r[id_r];
    old7 = lzo_pkg::POS_W'(old);
    top7 = $signed({1'b0, vis_r}) - 7'sd1;
    lim9 = (old >= 0) ? 9'(top7) : $signed({3'b000, vis_r});
    h9   = 9'(req_r);
    if (h9 > lim9) begin
      h9 = lim9;
    end
    if (h9 < -9'sd1) begin
      h9 = -9'sd1;
    end
    hc7   = h9[lzo_pkg::POS_W-1:0];
    st_c  = lzo_pkg::ST_SAME;
    rlo_c = 7'sd1;
    rhi_c = 7'sd0;
    up_c  = 1'b0;
    map_c = '0;
    df_c  = '0;
    dt_c  = -6'sd1;
    vis_c = vis_r;
    if (old7 > hc7) begin
      if (hc7 >= 0) begin
        st_c  = lzo_pkg::ST_LOWER;
        rlo_c = hc7;
        rhi_c = old7 - 7'sd1;
        up_c  = 1'b1;
        map_c = 5'(hc7 + 7'sd1);
        df_c  = 5'(hc7 + 7'sd1);
        dt_c  = old;
      end else begin
        st_c  = lzo_pkg::ST_HIDE;
        rlo_c = old7 + 7'sd1;
        rhi_c = top7;
        dt_c  = old - 6'sd1;
        vis_c = vis_r - 6'd1;
      end
    end else if (old7 < hc7) begin
      if (old7 >= 0) begin
        st_c  = lzo_pkg::ST_RAISE;
        rlo_c = old7 + 7'sd1;
        rhi_c = hc7;
      end else begin
        st_c  = lzo_pkg::ST_SHOW;
        rlo_c = hc7;
        rhi_c = top7;
        up_c  = 1'b1;
        vis_c = vis_r + 6'd1;
      end
      map_c = 5'(hc7);
      df_c  = 5'(hc7);
      dt_c  = 6'(hc7);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      pl_hc_r  <= 6'(hc7);
      pl_st_r  <= st_c;
      pl_rlo_r <= rlo_c;
      pl_rhi_r <= rhi_c;
      pl_up_r  <= up_c;
      pl_map_r <= map_c;
      pl_df_r  <= df_c;
      pl_dt_r  <= dt_c;
      pl_vis_r <= vis_c;
    end
  end

  assign place = (pl_st_r != lzo_pkg::ST_SAME) && (pl_st_r != lzo_pkg::ST_HIDE);

  // slot cells: the planned slot takes the requested layer; others take a moving neighbor's owner
  for (genvar s = 0; s < LC; s++) begin : g_cell
    localparam logic signed [lzo_pkg::POS_W-1:0] SP = lzo_pkg::POS_W'(s);
    logic from_below, from_above;
    if (s > 0) begin : g_below
      assign from_below = pl_up_r && (SP - 7'sd1 >= pl_rlo_r) && (SP - 7'sd1 <= pl_rhi_r);
    end else begin : g_nobelow
      assign from_below = 1'b0;
    end
    if (s < LC - 1) begin : g_above
      assign from_above = !pl_up_r && (SP + 7'sd1 >= pl_rlo_r) && (SP + 7'sd1 <= pl_rhi_r);
    end else begin : g_noabove
      assign from_above = 1'b0;
    end
    always_comb begin
      owner_nxt[s] = owner_r[s];
      if (place && (lzo_pkg::POS_W'(pl_hc_r) == SP)) begin
        owner_nxt[s] = id_r;
      end else if (from_below) begin
        owner_nxt[s] = owner_r[(s > 0) ? s - 1 : s];
      end else if (from_above) begin
        owner_nxt[s] = owner_r[(s < LC - 1) ? s + 1 : s];
      end
    end
    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        owner_r[s] <= owner_nxt[s];
      end
    end
  end

  // per-layer slot map: the requested layer takes its planned slot, layers inside the moved range step by one
  for (genvar j = 0; j < LC; j++) begin : g_layer
    logic signed [lzo_pkg::POS_W-1:0] p;
    assign p = lzo_pkg::POS_W'(lslot_r[j]);
    always_comb begin
      lslot_nxt[j] = lslot_r[j];
      if (id_r == lzo_pkg::ID_W'(j)) begin
        lslot_nxt[j] = pl_hc_r;
      end else if ((p >= pl_rlo_r) && (p <= pl_rhi_r)) begin
        lslot_nxt[j] = pl_up_r ? lslot_r[j] + 6'sd1 : lslot_r[j] - 6'sd1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lslot_r[j] <= -6'sd1;
      end else if (cmd.apply) begin
        lslot_r[j] <= lslot_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.apply) begin
        vis_r       <= pl_vis_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_slot_r <= pl_hc_r;
      res_st_r   <= pl_st_r;
      res_map_r  <= pl_map_r;
      res_df_r   <= pl_df_r;
      res_dt_r   <= pl_dt_r;
    end
  end

  assign sts.out_busy      = out_valid_r && !out_ready;
  assign out_valid         = out_valid_r;
  assign out_new_slot      = res_slot_r;
  assign out_status        = res_st_r;
  assign out_map_from      = res_map_r;
  assign out_draw_from     = res_df_r;
  assign out_draw_to       = res_dt_r;
  assign out_visible_count = vis_r;

`ifndef ASSERT_OFF
  a_apply_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid_r)
    else $error("apply did not load the result register");

  a_vis_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    vis_r <= lzo_pkg::CNT_W'(LC))
    else $error("visible count above layer count");

  a_layer_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> lslot_r[$past(id_r)] == $past(pl_hc_r))
    else $error("moved layer not at its planned slot");

  a_apply_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> !(out_valid_r && !out_ready))
    else $error("result overwritten before transfer");
`endif

endmodule

[hdl/layer_z_order_manager.sv]
// Top level of the layer z-order manager.
// Keeps the stacking order of 32 display layers. Each request names a layer and a
// wanted height; the height is clamped (below -1 hides, a visible layer stops at the
// current top, a hidden one at one above it) and the layer is lowered, raised, shown
// or hidden while the layers in between shift one slot in parallel. One result per
// request gives the new slot, a status code, the redraw ranges and the visible count.
// The result is registered once the request has passed the plan and apply states of
// the sequencer; apply waits while an earlier result is still unread. The next request
// is taken while the previous result waits in the output register, but not before the
// previous request has been applied.
module layer_z_order_manager (
  input  logic          clk,
  input  logic          rst_n,
  lzo_req_if.sink       in_chan,
  lzo_res_if.source     out_chan
);

  lzo_pkg::ctl_cmd_t cmd;
  lzo_pkg::ctl_sts_t sts;

  lzo_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzo_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_layer_sel        (in_chan.layer_sel),
    .in_requested_height (in_chan.requested_height),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_new_slot        (out_chan.new_slot),
    .out_status          (out_chan.status),
    .out_map_from        (out_chan.map_from),
    .out_draw_from       (out_chan.draw_from),
    .out_draw_to         (out_chan.draw_to),
    .out_visible_count   (out_chan.visible_count)
  );

endmodule
